FILE: hdl/ple_pkg.sv
// Package for the positional list engine.
// Holds the command and result word types, opcodes, status codes and the
// per-cycle control word that the controller broadcasts to the cell row.
package ple_pkg;

	typedef enum logic [2:0] {
		OP_INS_END   = 3'd0,
		OP_INS_FRONT = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DUMP      = 3'd3,
		OP_UPDATE    = 3'd4,
		OP_DEL_FRONT = 3'd5,
		OP_DEL_END   = 3'd6,
		OP_DEL_POS   = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Command word
	typedef struct packed {
		opcode_t            opcode;
		logic [7:0]         position;
		logic signed [31:0] value;
	} cmd_word_t;

	// Result word
	typedef struct packed {
		status_t            status;
		logic               entry_valid;
		logic [4:0]         entry_index;
		logic signed [31:0] entry_value;
		logic               last;
	} rsp_word_t;

	// Row-wide control, same for every cell in a given cycle
	typedef struct packed {
		logic ins;        // open a hole at the index, write there
		logic del;        // close the entry at the index
		logic upd;        // overwrite the entry at the index
		logic dump_load;  // snapshot values into the dump chain
		logic dump_shift; // move the dump chain one step to the front
	} cell_ctl_t;

endpackage

FILE: hdl/ple_cell.sv
// One slot of the list row: a value register and a dump register.
// Depends on ple_pkg for the row control word.
module ple_cell
	import ple_pkg::*;
#(
	parameter int POS         = 0,
	parameter int IW          = 5,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  cell_ctl_t              ctl,
	input  logic [IW-1:0]          idx,
	input  logic [VALUE_WIDTH-1:0] wdata,
	input  logic [VALUE_WIDTH-1:0] left_val,
	input  logic [VALUE_WIDTH-1:0] right_val,
	input  logic [VALUE_WIDTH-1:0] right_dump,
	output logic [VALUE_WIDTH-1:0] val_q,
	output logic [VALUE_WIDTH-1:0] dump_q
);

	localparam logic [IW-1:0] MyPos = IW'(POS);

	// Slot value: shift in from a neighbor or take the new word
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MyPos > idx) begin
				val_q <= left_val;
			end else if (MyPos == idx) begin
				val_q <= wdata;
			end
		end else if (ctl.del) begin
			if (MyPos >= idx) begin
				val_q <= right_val;
			end
		end else if (ctl.upd && MyPos == idx) begin
			val_q <= wdata;
		end
	end

	// Dump chain: snapshot, then move toward the front one slot per cycle
	always_ff @(posedge clk) begin
		if (ctl.dump_load) begin
			dump_q <= val_q;
		end else if (ctl.dump_shift) begin
			dump_q <= right_dump;
		end
	end

endmodule

FILE: hdl/ple_ctrl.sv
// Controller: decodes commands, keeps the length, sequences dumps and
// registers the result word. Depends on ple_pkg.
module ple_ctrl
	import ple_pkg::*;
#(
	parameter int CAPACITY    = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  cmd_word_t                             cmd,
	input  logic [VALUE_WIDTH-1:0]                front_dump,
	output logic                                  busy,
	output cell_ctl_t                             ctl,
	output logic [$clog2(CAPACITY)-1:0]           idx,
	output logic [VALUE_WIDTH-1:0]                wdata,
	output rsp_word_t                             result,
	output logic                                  result_strobe
);

	localparam int IW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > 8) ? LW : 8) + 1;

	logic [LW-1:0] length_q;
	logic          dumping_q;
	logic [IW-1:0] cnt_q;
	rsp_word_t     result_q;
	logic          strobe_q;

	logic          accept;
	logic [CW-1:0] pos_w;
	logic [CW-1:0] len_w;
	logic          pos_nz;
	logic          pos_in_list;
	logic          pos_in_ins;
	logic          full;
	logic          empty;
	status_t       st;
	logic          op_ins;
	logic          op_del;
	logic          op_upd;
	logic          dump_last;
	logic [4:0]    dump_index;
	logic [31:0]   dump_value;

	assign accept = start && !dumping_q;
	assign busy   = dumping_q;

	// Position range checks
	assign pos_w       = CW'(cmd.position);
	assign len_w       = CW'(length_q);
	assign pos_nz      = (cmd.position != 8'd0);
	assign pos_in_list = pos_nz && (pos_w <= len_w);
	assign pos_in_ins  = pos_nz && (pos_w <= len_w + CW'(1));
	assign full        = (length_q == LW'(CAPACITY));
	assign empty       = (length_q == '0);

	// Command decode: status, target index, kind of row move
	always_comb begin
		st     = ST_OK;
		idx    = '0;
		op_ins = 1'b0;
		op_del = 1'b0;
		op_upd = 1'b0;
		case (cmd.opcode)
			OP_INS_END: begin
				op_ins = 1'b1;
				idx    = IW'(length_q);
				st     = full ? ST_FULL : ST_OK;
			end
			OP_INS_FRONT: begin
				op_ins = 1'b1;
				st     = full ? ST_FULL : ST_OK;
			end
			OP_INS_POS: begin
				op_ins = 1'b1;
				idx    = IW'(cmd.position - 8'd1);
				if (!pos_in_ins) begin
					st = ST_INVALID;
				end else if (full) begin
					st = ST_FULL;
				end
			end
			OP_UPDATE: begin
				op_upd = 1'b1;
				idx    = IW'(cmd.position - 8'd1);
				st     = pos_in_list ? ST_OK : ST_INVALID;
			end
			OP_DEL_FRONT: begin
				op_del = 1'b1;
				st     = empty ? ST_INVALID : ST_OK;
			end
			OP_DEL_END: begin
				op_del = 1'b1;
				idx    = IW'(length_q - LW'(1));
				st     = empty ? ST_INVALID : ST_OK;
			end
			OP_DEL_POS: begin
				op_del = 1'b1;
				idx    = IW'(cmd.position - 8'd1);
				st     = pos_in_list ? ST_OK : ST_INVALID;
			end
			OP_DUMP: begin
				st = empty ? ST_INVALID : ST_OK;
			end
			default: begin
				st = ST_INVALID;
			end
		endcase
	end

	// Row control for this cycle
	always_comb begin
		ctl            = '0;
		ctl.ins        = accept && op_ins && (st == ST_OK);
		ctl.del        = accept && op_del && (st == ST_OK);
		ctl.upd        = accept && op_upd && (st == ST_OK);
		ctl.dump_load  = accept && (cmd.opcode == OP_DUMP) && !empty;
		ctl.dump_shift = dumping_q;
	end

	// New word: sign-extend or truncate to the slot width
	for (genvar b = 0; b < VALUE_WIDTH; b++) begin : g_wdata
		if (b < 32) begin : g_lo
			assign wdata[b] = cmd.value[b];
		end else begin : g_hi
			assign wdata[b] = cmd.value[31];
		end
	end

	// Dumped entry: low 32 bits of the slot, zero-filled if narrower
	for (genvar b = 0; b < 32; b++) begin : g_dval
		if (b < VALUE_WIDTH) begin : g_lo
			assign dump_value[b] = front_dump[b];
		end else begin : g_hi
			assign dump_value[b] = 1'b0;
		end
	end

	for (genvar b = 0; b < 5; b++) begin : g_didx
		if (b < IW) begin : g_lo
			assign dump_index[b] = cnt_q[b];
		end else begin : g_hi
			assign dump_index[b] = 1'b0;
		end
	end

	assign dump_last = ((LW'(cnt_q) + LW'(1)) == length_q);

	// Length and dump sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= '0;
			dumping_q <= 1'b0;
			cnt_q     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			// one word per dump step, or one status word per plain command
			strobe_q <= dumping_q || (accept && !ctl.dump_load);
			if (dumping_q) begin
				cnt_q <= cnt_q + IW'(1);
				if (dump_last) begin
					dumping_q <= 1'b0;
				end
			end else if (accept) begin
				if (ctl.dump_load) begin
					dumping_q <= 1'b1;
					cnt_q     <= '0;
				end
				if (ctl.ins) begin
					length_q <= length_q + LW'(1);
				end else if (ctl.del) begin
					length_q <= length_q - LW'(1);
				end
			end
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (dumping_q) begin
			result_q.status      <= ST_OK;
			result_q.entry_valid <= 1'b1;
			result_q.entry_index <= dump_index;
			result_q.entry_value <= dump_value;
			result_q.last        <= dump_last;
		end else if (accept) begin
			result_q.status      <= st;
			result_q.entry_valid <= 1'b0;
			result_q.entry_index <= '0;
			result_q.entry_value <= '0;
			result_q.last        <= 1'b1;
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

FILE: hdl/positional_list_engine.sv
// Positional list engine on ple_pkg, ple_ctrl and ple_cell: a bounded list in a cell row.
// Latency: a status word is on the ports in the cycle after its command is
// taken; a dump's entry words come after the snapshot and the busy register,
// then one per cycle. Throughput: one command per cycle while busy is low;
// a dump of N entries holds busy until the one-slot-per-cycle dump chain gives its last.
// Reset clears the length and sequencer; slots are undefined. Results never stall.
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY    = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  cmd_word_t cmd,
	output rsp_word_t result,
	output logic      result_strobe
);

	localparam int IW = $clog2(CAPACITY);

	cell_ctl_t              ctl;
	logic [IW-1:0]          idx;
	logic [VALUE_WIDTH-1:0] wdata;
	logic [VALUE_WIDTH-1:0] val   [CAPACITY];
	logic [VALUE_WIDTH-1:0] dump  [CAPACITY];

	ple_ctrl #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.front_dump    (dump[0]),
		.busy          (busy),
		.ctl           (ctl),
		.idx           (idx),
		.wdata         (wdata),
		.result        (result),
		.result_strobe (result_strobe)
	);

	// Cell row; end cells loop their own outputs where no neighbor exists
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_val;
		logic [VALUE_WIDTH-1:0] right_val;
		logic [VALUE_WIDTH-1:0] right_dump;

		if (i == 0) begin : g_first
			assign left_val = val[i];
		end else begin : g_mid
			assign left_val = val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val  = val[i];
			assign right_dump = dump[i];
		end else begin : g_inner
			assign right_val  = val[i+1];
			assign right_dump = dump[i+1];
		end

		ple_cell #(
			.POS         (i),
			.IW          (IW),
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.idx        (idx),
			.wdata      (wdata),
			.left_val   (left_val),
			.right_val  (right_val),
			.right_dump (right_dump),
			.val_q      (val[i]),
			.dump_q     (dump[i])
		);
	end

endmodule

FILE: bench/ple_checker.sv
// Scoreboard for the positional list engine: watches the command and result
// words, keeps its own copy of the list to predict results, compares them.
// Depends on ple_pkg.
`timescale 1ns / 100ps

module ple_checker
	import ple_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  cmd_word_t   cmd,
	input  rsp_word_t   result,
	input  logic        result_strobe,
	output int unsigned fail_count,
	output int unsigned outstanding,
	output int unsigned held_count,
	output int unsigned words_checked
);

	// Shadow copy of the list
	logic signed [31:0] shadow_vals [CAPACITY];
	int unsigned        shadow_len;
	rsp_word_t          expected_words [$];

	function automatic rsp_word_t status_word(input status_t st);
		rsp_word_t w;
		w = '0;
		w.status = st;
		w.last   = 1'b1;
		return w;
	endfunction

	// Open a hole at idx and store v there; position checked before fullness
	task automatic shadow_insert(input int unsigned idx, input logic signed [31:0] v,
		output status_t st);
		int unsigned i;
		if (idx > shadow_len) begin
			st = ST_INVALID;
		end else if (shadow_len >= CAPACITY) begin
			st = ST_FULL;
		end else begin
			for (i = shadow_len; i > idx; i--)
				shadow_vals[i] = shadow_vals[i - 1];
			shadow_vals[idx] = v;
			shadow_len++;
			st = ST_OK;
		end
	endtask

	// Close the entry at idx
	task automatic shadow_delete(input int unsigned idx, output status_t st);
		int unsigned i;
		if (idx >= shadow_len) begin
			st = ST_INVALID;
		end else begin
			for (i = idx; i + 1 < shadow_len; i++)
				shadow_vals[i] = shadow_vals[i + 1];
			shadow_len--;
			st = ST_OK;
		end
	endtask

	// Apply one command to the shadow list and queue the words it should cause
	task automatic predict_list_op(input cmd_word_t c);
		status_t     st;
		rsp_word_t   w;
		int unsigned i;
		st = ST_OK;
		if (c.opcode == OP_DUMP) begin
			if (shadow_len == 0) begin
				expected_words.push_back(status_word(ST_INVALID));
			end else begin
				for (i = 0; i < shadow_len; i++) begin
					w             = '0;
					w.status      = ST_OK;
					w.entry_valid = 1'b1;
					w.entry_index = i[4:0];
					w.entry_value = shadow_vals[i];
					w.last        = (i + 1 == shadow_len);
					expected_words.push_back(w);
				end
			end
		end else begin
			case (c.opcode)
				OP_INS_END:   shadow_insert(shadow_len, c.value, st);
				OP_INS_FRONT: shadow_insert(0, c.value, st);
				OP_INS_POS: begin
					if (c.position == 0) st = ST_INVALID;
					else shadow_insert(c.position - 1, c.value, st);
				end
				OP_UPDATE: begin
					if (c.position == 0 || c.position > shadow_len) st = ST_INVALID;
					else shadow_vals[c.position - 1] = c.value;
				end
				OP_DEL_FRONT: shadow_delete(0, st);
				OP_DEL_END: begin
					if (shadow_len == 0) st = ST_INVALID;
					else shadow_delete(shadow_len - 1, st);
				end
				OP_DEL_POS: begin
					if (c.position == 0) st = ST_INVALID;
					else shadow_delete(c.position - 1, st);
				end
				default: st = ST_INVALID;
			endcase
			expected_words.push_back(status_word(st));
		end
	endtask

	// Compare one result word against the oldest expectation
	task automatic check_word(input rsp_word_t got);
		rsp_word_t want;
		if (expected_words.size() == 0) begin
			$error("result word with nothing pending: status %0d value %0d",
				got.status, $signed(got.entry_value));
			fail_count++;
		end else begin
			want = expected_words.pop_front();
			words_checked++;
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fail_count++;
			end
			if (got.entry_valid !== want.entry_valid) begin
				$error("entry_valid: expected %0d, got %0d", want.entry_valid,
					got.entry_valid);
				fail_count++;
			end
			if (got.entry_index !== want.entry_index) begin
				$error("entry_index: expected %0d, got %0d", want.entry_index,
					got.entry_index);
				fail_count++;
			end
			if (got.entry_value !== want.entry_value) begin
				$error("entry_value: expected %0d, got %0d", $signed(want.entry_value),
					$signed(got.entry_value));
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				fail_count++;
			end
		end
	endtask

	// Results first, so a word never meets an expectation queued at its own edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len = 0;
			expected_words.delete();
			fail_count    = 0;
			words_checked = 0;
			outstanding <= 0;
			held_count  <= 0;
		end else begin
			if (result_strobe)
				check_word(result);
			if (start && !busy)
				predict_list_op(cmd);
			outstanding <= expected_words.size();
			held_count  <= shadow_len;
		end
	end

endmodule

FILE: bench/positional_list_engine_tb.sv
// Testbench top for the positional list engine: drives command words with
// directed and random traffic, and gives the verdict from ple_checker.
// Depends on ple_pkg, positional_list_engine and ple_checker.
`timescale 1ns / 100ps

module positional_list_engine_tb;
	import ple_pkg::*;

	localparam int CAPACITY    = 32;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_word_t   cmd;
	rsp_word_t   result;
	logic        result_strobe;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned held_count;
	int unsigned words_checked;
	int unsigned cycle_count = 0;
	int unsigned words_sent  = 0;
	bit          gaps_on     = 1'b1;

	positional_list_engine #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (32)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.result        (result),
		.result_strobe (result_strobe)
	);

	ple_checker #(
		.CAPACITY (CAPACITY)
	) list_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.result        (result),
		.result_strobe (result_strobe),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.held_count    (held_count),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// One command word; start stays high across back-to-back words
	task automatic send_command(input opcode_t op, input logic [7:0] pos,
		input logic [31:0] val);
		cmd_word_t w;
		if (gaps_on && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		w.opcode   = op;
		w.position = pos;
		w.value    = val;
		start <= 1'b1;
		cmd   <= w;
		do @(posedge clk); while (busy);
		words_sent++;
	endtask

	// Hold off until every pending result word has come back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Mostly valid positions around the current length, some out of range
	function automatic logic [7:0] make_position();
		int unsigned r;
		int unsigned top;
		r   = $urandom_range(0, 99);
		top = (held_count + 1 > 255) ? 255 : held_count + 1;
		if (r < 78) return 8'($urandom_range(1, top));
		if (r < 86) return 8'd0;
		if (r < 93) return 8'(held_count + $urandom_range(1, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] make_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)  return 32'h8000_0000;
		if (r < 16) return 32'h7fff_ffff;
		if (r < 21) return 32'hffff_ffff;
		if (r < 25) return 32'h0;
		return $urandom;
	endfunction

	// Random command; grow_pct sets the share of inserts
	task automatic random_command(input int unsigned grow_pct);
		int unsigned r;
		opcode_t     op;
		r = $urandom_range(0, 99);
		if (r < grow_pct) begin
			case ($urandom_range(0, 2))
				0:       op = OP_INS_END;
				1:       op = OP_INS_FRONT;
				default: op = OP_INS_POS;
			endcase
		end else if (r < grow_pct + 7) begin
			op = OP_DUMP;
		end else begin
			case ($urandom_range(0, 5))
				0:       op = OP_UPDATE;
				1:       op = OP_DEL_FRONT;
				2:       op = OP_DEL_END;
				3:       op = OP_UPDATE;
				default: op = OP_DEL_POS;
			endcase
		end
		send_command(op, make_position(), make_value());
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty list: every remove, update and dump is refused
		send_command(OP_DUMP,      8'd0,   32'h0);
		send_command(OP_DEL_FRONT, 8'd0,   32'h0);
		send_command(OP_DEL_END,   8'd0,   32'h0);
		send_command(OP_DEL_POS,   8'd1,   32'h0);
		send_command(OP_UPDATE,    8'd1,   32'h1234_5678);
		send_command(OP_INS_POS,   8'd0,   32'h1);
		send_command(OP_INS_POS,   8'd2,   32'h2);
		// Build a short list with extreme values
		send_command(OP_INS_POS,   8'd1,   32'h8000_0000);
		send_command(OP_INS_END,   8'd0,   32'h7fff_ffff);
		send_command(OP_INS_FRONT, 8'd0,   32'h0);
		send_command(OP_INS_FRONT, 8'd255, 32'hffff_ffff);
		send_command(OP_INS_POS,   8'd5,   32'h5a5a_5a5a);
		send_command(OP_INS_POS,   8'd255, 32'h3);
		// Update edges: zero, last valid, one past the end
		send_command(OP_UPDATE,    8'd0,   32'h4);
		send_command(OP_UPDATE,    8'd5,   32'ha5a5_a5a5);
		send_command(OP_UPDATE,    8'd6,   32'h5);
		send_command(OP_DUMP,      8'd0,   32'h0);
		// Removals, valid and out of range
		send_command(OP_DEL_POS,   8'd3,   32'h0);
		send_command(OP_DEL_POS,   8'd255, 32'h0);
		send_command(OP_DEL_POS,   8'd0,   32'h0);
		send_command(OP_DEL_END,   8'd0,   32'h0);
		send_command(OP_DEL_FRONT, 8'd0,   32'h0);
		send_command(OP_DUMP,      8'd0,   32'h0);
		drain_results();

		// Mixed traffic around a short list
		repeat (20) random_command(45);
		drain_results();

		// Back-to-back growth until the list is full and inserts bounce
		gaps_on = 1'b0;
		repeat (55) random_command(90);
		gaps_on = 1'b1;
		drain_results();
		send_command(OP_DUMP, 8'd0, 32'h0);

		// Drain the list back toward empty
		repeat (35) random_command(5);
		send_command(OP_DUMP, 8'd0, 32'h0);

		drain_results();
		repeat (10) @(posedge clk);
		$display("Sent %0d commands and checked %0d result words, list filled to capacity",
			words_sent, words_checked);
		$display("and drained again, with gaps and back-to-back traffic.");
		if (fail_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
